// ----- sv/depth_to_color_ramp_defines.svh -----
// ----------------------------------------------------------------------------
// Depth to colour ramp: assertion macros
// Immediate-implication and next-cycle checks used by the divider pipeline.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_COLOR_RAMP_DEFINES_SVH
`define DEPTH_TO_COLOR_RAMP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define DCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("depth_to_color_ramp: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define DCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("depth_to_color_ramp: next-cycle check failed");

`endif

// ----- sv/dcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth to colour ramp package
// Widths, register indexes, segment codes and the colour lookup function.
// ----------------------------------------------------------------------------
package dcr_pkg;

   // Default sample width in bits
   localparam int DEPTH_BITS_DEF = 16;

   // Ramp length and quotient width (positions 0 .. 2047, six segments used)
   localparam int RAMP_SPAN = 1530;
   localparam int Q_BITS    = 11;

   // Register reset values
   localparam int RANGE_LOW_RESET  = 0;
   localparam int RANGE_HIGH_RESET = 65535;

   // Register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH = 1'b1;

   // Full-scale channel value
   localparam logic [7:0] FULL = 8'hFF;

   // Segment codes (position divided by 256)
   localparam logic [2:0] SEG_WHITE_TO_RED    = 3'd0;
   localparam logic [2:0] SEG_RED_TO_YELLOW   = 3'd1;
   localparam logic [2:0] SEG_YELLOW_TO_GREEN = 3'd2;
   localparam logic [2:0] SEG_GREEN_TO_CYAN   = 3'd3;
   localparam logic [2:0] SEG_CYAN_TO_BLUE    = 3'd4;
   localparam logic [2:0] SEG_BLUE_TO_BLACK   = 3'd5;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } colour_type;

   // Map a ramp position to a colour; overflow, zero and segments past five are black
   function automatic colour_type ramp_colour(input logic [Q_BITS-1:0] pos,
                                              input logic ovf);
      colour_type c;
      logic [7:0] lb;
      logic [7:0] nlb;
      logic [2:0] seg;
      lb  = pos[7:0];
      nlb = FULL - lb;
      seg = pos[Q_BITS-1:8];
      c   = '0;
      if (!ovf && (pos != '0)) begin
         case (seg)
            SEG_WHITE_TO_RED: begin
               c.blue = nlb;  c.green = nlb;  c.red = FULL;
            end
            SEG_RED_TO_YELLOW: begin
               c.blue = '0;   c.green = lb;   c.red = FULL;
            end
            SEG_YELLOW_TO_GREEN: begin
               c.blue = '0;   c.green = FULL; c.red = nlb;
            end
            SEG_GREEN_TO_CYAN: begin
               c.blue = lb;   c.green = FULL; c.red = '0;
            end
            SEG_CYAN_TO_BLUE: begin
               c.blue = FULL; c.green = nlb;  c.red = '0;
            end
            SEG_BLUE_TO_BLACK: begin
               c.blue = nlb;  c.green = '0;   c.red = '0;
            end
            default: c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

// ----- sv/depth_to_color_ramp.sv -----
// ----------------------------------------------------------------------------
// Depth to colour ramp
// Maps one depth sample per transfer to blue, green and red bytes on a
// six-segment ramp between two programmable depths.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_depth_mm carry one depth sample per transfer;
//   rsp_valid/rsp_stall/rsp_blue/rsp_green/rsp_red return one colour per
//   sample, in order. A transfer happens when valid is high and stall low.
//   csr_write with csr_index and csr_wdata sets range_low (index 0) or
//   range_high (index 1); write only while no sample is in flight.
//   A request transfer reaches rsp_valid through range subtract, constant
//   multiply by 1530, overflow compare, eleven restoring divider stages
//   (one quotient bit each) and the colour output register.
//   Throughput is one sample per cycle while rsp_stall stays low; each
//   divider stage is a single compare and subtract across the numerator width.
//   Reset empties the pipeline and sets range_low to 0 and range_high to
//   65535 (truncated to the sample width).
//   When rsp_stall is high, a held result stays put and the stages behind it
//   keep filling empty slots; req_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
module depth_to_color_ramp #(
   parameter int DEPTH_BITS = dcr_pkg::DEPTH_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [DEPTH_BITS-1:0]               req_depth_mm,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_blue,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_red,
   input  logic                                csr_write,
   input  logic [dcr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DEPTH_BITS-1:0]               csr_wdata
);

   localparam int REM_BITS = DEPTH_BITS + dcr_pkg::Q_BITS;

   logic [DEPTH_BITS-1:0]        range_low_ff;
   logic [DEPTH_BITS-1:0]        range_high_ff;
   logic                         range_ok;
   logic [DEPTH_BITS-1:0]        denom;

   logic                         s0_vld_ff;
   logic [DEPTH_BITS-1:0]        s0_diff_ff;
   logic [DEPTH_BITS-1:0]        s0_diff_in;
   logic                         s1_vld_ff;
   logic [REM_BITS-1:0]          s1_numer_ff;
   logic [REM_BITS-1:0]          s1_numer_in;

   logic                         div_in_stall;
   logic                         div_out_valid;
   logic                         div_out_stall;
   logic [dcr_pkg::Q_BITS-1:0]   div_quot;
   logic                         div_ovf;

   logic                         s0_en;
   logic                         s1_en;
   logic                         out_en;

   logic                         rsp_valid_ff;
   dcr_pkg::colour_type          colour_ff;
   dcr_pkg::colour_type          colour_in;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= DEPTH_BITS'(dcr_pkg::RANGE_LOW_RESET);
         range_high_ff <= DEPTH_BITS'(dcr_pkg::RANGE_HIGH_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            dcr_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            dcr_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign range_ok = (range_high_ff > range_low_ff);
   assign denom    = range_ok ? (range_high_ff - range_low_ff) : '0;

   // Advance chain from the output back to the request side
   assign out_en        = !rsp_valid_ff || !rsp_stall;
   assign div_out_stall = !out_en;
   assign s1_en         = !s1_vld_ff || !div_in_stall;
   assign s0_en         = !s0_vld_ff || s1_en;
   assign req_stall     = !s0_en;

   // Stage 0: offset from range start, zero at or below it or on an empty range
   assign s0_diff_in = (range_ok && (req_depth_mm > range_low_ff)) ?
                       (req_depth_mm - range_low_ff) : '0;

   // Stage 1: scale by the ramp length
   assign s1_numer_in = REM_BITS'(s0_diff_ff) * REM_BITS'(dcr_pkg::RAMP_SPAN);

   // Output stage: colour lookup
   assign colour_in = dcr_pkg::ramp_colour(div_quot, div_ovf);

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_en) begin
            s0_vld_ff <= req_valid;
         end
         if (s1_en) begin
            s1_vld_ff <= s0_vld_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= div_out_valid;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (s0_en) begin
         s0_diff_ff <= s0_diff_in;
      end
      if (s1_en) begin
         s1_numer_ff <= s1_numer_in;
      end
      if (out_en) begin
         colour_ff <= colour_in;
      end
   end

   dcr_div_pipe #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_stall  (div_in_stall),
      .in_numer  (s1_numer_ff),
      .in_denom  (denom),
      .out_valid (div_out_valid),
      .out_stall (div_out_stall),
      .out_quot  (div_quot),
      .out_ovf   (div_ovf)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_blue  = colour_ff.blue;
   assign rsp_green = colour_ff.green;
   assign rsp_red   = colour_ff.red;

endmodule

// ----- sv/dcr_div_pipe.sv -----
// ----------------------------------------------------------------------------
// Depth to colour ramp: pipelined restoring divider
// One overflow stage, then one quotient bit per stage, with valid bits and a
// per-stage advance chain so bubbles close up under stall.
// ----------------------------------------------------------------------------
`include "depth_to_color_ramp_defines.svh"

module dcr_div_pipe #(
   parameter int DEPTH_BITS = dcr_pkg::DEPTH_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_stall,
   input  logic [DEPTH_BITS+dcr_pkg::Q_BITS-1:0] in_numer,
   input  logic [DEPTH_BITS-1:0]                 in_denom,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic [dcr_pkg::Q_BITS-1:0]            out_quot,
   output logic                                  out_ovf
);

   localparam int Q_BITS   = dcr_pkg::Q_BITS;
   localparam int REM_BITS = DEPTH_BITS + Q_BITS;
   localparam int NSTG     = Q_BITS + 1;

   logic [NSTG-1:0]     vld_ff;
   logic [NSTG-1:0]     ovf_ff;
   logic [NSTG-1:0]     ovf_in;
   logic [REM_BITS-1:0] rem_ff [NSTG];
   logic [REM_BITS-1:0] rem_in [NSTG];
   logic [Q_BITS-1:0]   quo_ff [NSTG];
   logic [Q_BITS-1:0]   quo_in [NSTG];
   logic [REM_BITS-1:0] trial  [NSTG];
   logic [NSTG-1:0]     stage_en;

   // Stage 0 flags overflow, stage j settles quotient bit Q_BITS-j
   always_comb begin
      trial[0]  = REM_BITS'(in_denom) << Q_BITS;
      rem_in[0] = in_numer;
      quo_in[0] = '0;
      ovf_in[0] = (in_numer >= trial[0]);
      for (int j = 1; j < NSTG; j++) begin
         trial[j]  = REM_BITS'(in_denom) << (Q_BITS - j);
         ovf_in[j] = ovf_ff[j-1];
         if (!ovf_ff[j-1] && (rem_ff[j-1] >= trial[j])) begin
            rem_in[j] = rem_ff[j-1] - trial[j];
            quo_in[j] = quo_ff[j-1] | (Q_BITS'(1) << (Q_BITS - j));
         end else begin
            rem_in[j] = rem_ff[j-1];
            quo_in[j] = quo_ff[j-1];
         end
      end
   end

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      stage_en[NSTG-1] = !vld_ff[NSTG-1] || !out_stall;
      for (int j = NSTG - 2; j >= 0; j--) begin
         stage_en[j] = !vld_ff[j] || stage_en[j+1];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int j = 1; j < NSTG; j++) begin
            if (stage_en[j]) begin
               vld_ff[j] <= vld_ff[j-1];
            end
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      for (int j = 0; j < NSTG; j++) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            ovf_ff[j] <= ovf_in[j];
         end
      end
   end

   assign in_stall  = !stage_en[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_quot  = quo_ff[NSTG-1];
   assign out_ovf   = ovf_ff[NSTG-1];

   // An empty entry stage always takes a transfer
   `DCR_ASSERT_NOW(a_entry_free, clock, reset, !vld_ff[0], !in_stall)
   // The final remainder lies below the divisor
   `DCR_ASSERT_NOW(a_rem_below_denom, clock, reset,
      vld_ff[NSTG-1] && !ovf_ff[NSTG-1], rem_ff[NSTG-1] < REM_BITS'(in_denom))
   // A stalled result is not dropped
   `DCR_ASSERT_NEXT(a_stall_keeps, clock, reset, out_valid && out_stall, out_valid)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth to colour ramp testbench
// Sends depth samples through the ramp block under several range settings.
// Each colour that comes back is checked against a local predictor. The
// sender and the receiver idle at random, and one long output hold fills
// the pipeline so that it has to stall its input.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DW           = dcr_pkg::DEPTH_BITS_DEF;
   localparam int CYCLE_LIMIT  = 120000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_GAP   = 24;
   localparam int SHOWN_ERRORS = 10;

   typedef struct {
      logic [DW-1:0]       depth;
      dcr_pkg::colour_type colour;
   } expected_pixel_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [DW-1:0]                      req_depth_mm;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [7:0]                         rsp_blue;
   logic [7:0]                         rsp_green;
   logic [7:0]                         rsp_red;
   logic                               csr_write;
   logic [dcr_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [DW-1:0]                      csr_wdata;

   // Local copy of the range registers
   logic [DW-1:0] range_lo = DW'(dcr_pkg::RANGE_LOW_RESET);
   logic [DW-1:0] range_hi = DW'(dcr_pkg::RANGE_HIGH_RESET);

   expected_pixel_type expected_colours[$];
   expected_pixel_type oldest_pixel;

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   bit long_hold     = 1'b0;
   int hold_count    = 0;
   int mismatches    = 0;
   int failures      = 0;
   int cycle_count   = 0;

   depth_to_color_ramp #(.DEPTH_BITS(DW)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_depth_mm (req_depth_mm),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_blue     (rsp_blue),
      .rsp_green    (rsp_green),
      .rsp_red      (rsp_red),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Colour expected for one depth under the current range
   function automatic dcr_pkg::colour_type depth_to_colour(input logic [DW-1:0] depth);
      logic [31:0]         pos;
      logic [31:0]         seg;
      logic [7:0]          lb;
      logic [7:0]          nlb;
      dcr_pkg::colour_type c;
      pos = '0;
      if (range_hi > range_lo && depth > range_lo)
         pos = (32'd1530 * 32'(depth - range_lo)) / 32'(range_hi - range_lo);
      seg = pos >> 8;
      lb  = pos[7:0];
      nlb = dcr_pkg::FULL - lb;
      c   = '0;
      if (pos != '0) begin
         case (seg)
            32'(dcr_pkg::SEG_WHITE_TO_RED): begin
               c.blue = nlb;           c.green = nlb;           c.red = dcr_pkg::FULL;
            end
            32'(dcr_pkg::SEG_RED_TO_YELLOW): begin
               c.blue = '0;            c.green = lb;            c.red = dcr_pkg::FULL;
            end
            32'(dcr_pkg::SEG_YELLOW_TO_GREEN): begin
               c.blue = '0;            c.green = dcr_pkg::FULL; c.red = nlb;
            end
            32'(dcr_pkg::SEG_GREEN_TO_CYAN): begin
               c.blue = lb;            c.green = dcr_pkg::FULL; c.red = '0;
            end
            32'(dcr_pkg::SEG_CYAN_TO_BLUE): begin
               c.blue = dcr_pkg::FULL; c.green = nlb;           c.red = '0;
            end
            32'(dcr_pkg::SEG_BLUE_TO_BLACK): begin
               c.blue = nlb;           c.green = '0;            c.red = '0;
            end
            default: c = '0;
         endcase
      end
      return c;
   endfunction

   // Receiver: random stall, or one long hold when asked for
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && hold_count < HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
            hold_count++;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // Check every colour transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_colours.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("unexpected colour b=%0d g=%0d r=%0d", rsp_blue, rsp_green, rsp_red);
         end else begin
            oldest_pixel = expected_colours.pop_front();
            if (rsp_blue !== oldest_pixel.colour.blue || rsp_green !== oldest_pixel.colour.green
                || rsp_red !== oldest_pixel.colour.red) begin
               failures++;
               mismatches++;
               if (mismatches <= SHOWN_ERRORS)
                  $display("depth %0d: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                           oldest_pixel.depth, oldest_pixel.colour.blue,
                           oldest_pixel.colour.green, oldest_pixel.colour.red,
                           rsp_blue, rsp_green, rsp_red);
            end
         end
      end
   end

   // Offer one depth sample, with random idle cycles before it; entered and left at a falling edge
   task automatic send_depth(input logic [DW-1:0] depth);
      expected_pixel_type pix;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_depth_mm <= depth;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pix.depth  = depth;
      pix.colour = depth_to_colour(depth);
      expected_colours.push_back(pix);
      @(negedge clock);
   endtask

   // Drop valid and wait until every colour has come back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_colours.size() != 0)
         @(negedge clock);
      repeat (SETTLE_GAP) @(negedge clock);
   endtask

   // Write both range registers; only called while the block is idle
   task automatic write_range(input logic [DW-1:0] lo, input logic [DW-1:0] hi);
      csr_write <= 1'b1;
      csr_index <= dcr_pkg::CSR_RANGE_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= dcr_pkg::CSR_RANGE_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_write <= 1'b0;
      range_lo = lo;
      range_hi = hi;
      @(negedge clock);
   endtask

   // Random depth, mostly inside the programmed range or a little past it
   function automatic logic [DW-1:0] random_depth();
      int lo;
      int hi;
      int top;
      lo = range_lo;
      hi = range_hi;
      case ($urandom_range(19))
         0, 1: return DW'($urandom_range(65535));
         2: return DW'($urandom_range(lo));
         default: begin
            if (hi <= lo)
               return DW'($urandom_range(65535));
            top = hi + (hi - lo) / 8;
            if (top > 65535)
               top = 65535;
            return DW'($urandom_range(top, lo));
         end
      endcase
   endfunction

   // Random range setting, extremes and empty ranges among them
   task automatic pick_range(output logic [DW-1:0] lo, output logic [DW-1:0] hi);
      int l;
      int h;
      case ($urandom_range(9))
         0: begin l = 0; h = 65535; end
         1: begin l = $urandom_range(65535); h = $urandom_range(l); end
         2: begin l = $urandom_range(65534); h = l + 1; end
         3: begin l = $urandom_range(64000); h = l + 1530; end
         4: begin l = 65535; h = 0; end
         default: begin
            l = $urandom_range(65000);
            if ($urandom_range(1))
               h = l + $urandom_range(500, 1);
            else
               h = $urandom_range(65535, l + 1);
         end
      endcase
      lo = DW'(l);
      hi = DW'(h);
   endtask

   // Reset range: zero and one, the top two depths and alternating bit patterns
   task automatic test_reset_range();
      send_depth(16'h0000);
      send_depth(16'h0001);
      send_depth(16'hFFFF);
      send_depth(16'hFFFE);
      send_depth(16'h5555);
      send_depth(16'hAAAA);
      settle();
   endtask

   // Span of exactly 1530 so that depth minus start is the ramp position
   task automatic test_segments();
      write_range(16'd1000, 16'd2530);
      send_depth(16'd999);
      send_depth(16'd1000);
      send_depth(16'd1001);
      send_depth(16'd1255);
      send_depth(16'd1256);
      send_depth(16'd1511);
      send_depth(16'd1768);
      send_depth(16'd2024);
      send_depth(16'd2279);
      send_depth(16'd2280);
      send_depth(16'd2530);
      send_depth(16'd2531);
      send_depth(16'd2536);
      send_depth(16'hFFFF);
      settle();
   endtask

   // Empty ranges give black; a one-wide range overflows past the ramp end
   task automatic test_empty_range();
      write_range(16'hFFFF, 16'hFFFF);
      send_depth(16'hFFFF);
      send_depth(16'h0000);
      settle();
      write_range(16'hAAAA, 16'h5555);
      send_depth(16'hFFFF);
      settle();
      write_range(16'h0000, 16'h0001);
      send_depth(16'h0001);
      send_depth(16'hFFFF);
      send_depth(16'h0000);
      settle();
   endtask

   // Hold the output for a long stretch while the sender keeps offering samples
   task automatic test_output_hold();
      int i;
      logic [DW-1:0] lo;
      logic [DW-1:0] hi;
      pick_range(lo, hi);
      write_range(lo, hi);
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      long_hold     = 1'b1;
      for (i = 0; i < 80; i++)
         send_depth(random_depth());
      settle();
   endtask

   // Random samples under a series of random range settings
   task automatic test_random_ramps(input int send_pct, input int rcv_pct, input int count);
      int i;
      logic [DW-1:0] lo;
      logic [DW-1:0] hi;
      send_idle_pct = send_pct;
      rcv_idle_pct  = rcv_pct;
      for (i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            settle();
            pick_range(lo, hi);
            write_range(lo, hi);
         end
         send_depth(random_depth());
      end
      settle();
   endtask

   // Main sequence
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_depth_mm = '0;
      csr_write    = 1'b0;
      csr_index    = dcr_pkg::CSR_RANGE_LOW;
      csr_wdata    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 30;
      rcv_idle_pct  = 80;
      test_reset_range();
      test_segments();
      test_empty_range();
      test_output_hold();
      test_random_ramps(30, 80, 420);
      test_random_ramps(80, 30, 420);
      test_random_ramps(0, 0, 420);

      repeat (SETTLE_GAP) @(negedge clock);
      if (expected_colours.size() != 0) begin
         failures += expected_colours.size();
         $display("%0d colours never arrived", expected_colours.size());
      end
      if (failures == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/dcr_pkg.sv
sv/dcr_div_pipe.sv
sv/depth_to_color_ramp.sv
tb/testbench.sv
